/* design/downward_expander_gate_assert.svh */
// ----------------------------------------------------------------------------
// Downward expander gate assertion macros
// Clocked property wrappers; ASSERT_OFF leaves the bodies empty.
// ----------------------------------------------------------------------------
`ifndef DOWNWARD_EXPANDER_GATE_ASSERT_SVH
`define DOWNWARD_EXPANDER_GATE_ASSERT_SVH

`ifndef ASSERT_OFF
// plain property, checked out of reset
`define DEG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("downward_expander_gate: assertion failed");
// antecedent implies consequent in the same cycle
`define DEG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("downward_expander_gate: implication failed");
// antecedent implies consequent in the next cycle
`define DEG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("downward_expander_gate: next-cycle check failed");
`else
`define DEG_ASSERT(lbl, clk, rst_n, prop)
`define DEG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DEG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* design/dexp_pkg.sv */
// ----------------------------------------------------------------------------
// Downward expander gate package
// Shared constants, controller states, register indexes and command bundle.
// ----------------------------------------------------------------------------
package dexp_pkg;

	localparam int SAMPLE_BITS_DEF    = 24;
	localparam int LOG_TABLE_BITS_DEF = 6;
	localparam int CFG_ADDR_W         = 3;
	localparam int CFG_DATA_W         = 24;

	// register indexes on the configuration port
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_SLOPE     = 3'd1,
		REG_ATTACK    = 3'd2,
		REG_RELEASE   = 3'd3,
		REG_CHANNELS  = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_SQ,
		ST_DB,
		ST_TGT,
		ST_SM1,
		ST_SM2,
		ST_GINIT,
		ST_GSTEP,
		ST_GFIN,
		ST_APL,
		ST_APR,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       norm;
		logic       sq;
		logic       db;
		logic       tgt;
		logic       sm1;
		logic       sm2;
		logic       ginit;
		logic       gstep;
		logic       gfin;
		logic       apl;
		logic       apr;
		logic       out_load;
		logic [3:0] step;
	} dp_cmd_t;

endpackage

/* design/dexp_ctrl.sv */
// ----------------------------------------------------------------------------
// Downward expander gate controller
// Sequences one frame through level, smoother, gain and output stages.
// ----------------------------------------------------------------------------
module dexp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_ready,
	output logic               in_ready,
	output logic               out_valid,
	output dexp_pkg::dp_cmd_t  cmd
);

	dexp_pkg::state_t state_q, state_d;
	logic [3:0]       cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// state, step counter and output word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dexp_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dexp_pkg::ST_SQ || state_q == dexp_pkg::ST_GSTEP)
				cnt_q <= cnt_q + 4'd1;
			else
				cnt_q <= '0;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.step = cnt_q;
		in_ready = 1'b0;
		case (state_q)
			dexp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = dexp_pkg::ST_NORM;
				end
			end
			dexp_pkg::ST_NORM: begin
				cmd.norm = 1'b1;
				state_d  = dexp_pkg::ST_SQ;
			end
			dexp_pkg::ST_SQ: begin
				cmd.sq = 1'b1;
				if (cnt_q == 4'd15)
					state_d = dexp_pkg::ST_DB;
			end
			dexp_pkg::ST_DB: begin
				cmd.db  = 1'b1;
				state_d = dexp_pkg::ST_TGT;
			end
			dexp_pkg::ST_TGT: begin
				cmd.tgt = 1'b1;
				state_d = dexp_pkg::ST_SM1;
			end
			dexp_pkg::ST_SM1: begin
				cmd.sm1 = 1'b1;
				state_d = dexp_pkg::ST_SM2;
			end
			dexp_pkg::ST_SM2: begin
				cmd.sm2 = 1'b1;
				state_d = dexp_pkg::ST_GINIT;
			end
			dexp_pkg::ST_GINIT: begin
				cmd.ginit = 1'b1;
				state_d   = dexp_pkg::ST_GSTEP;
			end
			dexp_pkg::ST_GSTEP: begin
				cmd.gstep = 1'b1;
				if (cnt_q == 4'd15)
					state_d = dexp_pkg::ST_GFIN;
			end
			dexp_pkg::ST_GFIN: begin
				cmd.gfin = 1'b1;
				state_d  = dexp_pkg::ST_APL;
			end
			dexp_pkg::ST_APL: begin
				cmd.apl = 1'b1;
				state_d = dexp_pkg::ST_APR;
			end
			dexp_pkg::ST_APR: begin
				cmd.apr = 1'b1;
				state_d = dexp_pkg::ST_OUT;
			end
			dexp_pkg::ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = dexp_pkg::ST_IDLE;
				end
			end
			default: state_d = dexp_pkg::ST_IDLE;
		endcase
	end

endmodule

/* design/dexp_datapath.sv */
// ----------------------------------------------------------------------------
// Downward expander gate datapath
// Level detector, dB smoother, exp2 gain unit, gain multiply and metering.
// ----------------------------------------------------------------------------
module dexp_datapath #(
	parameter int SAMPLE_BITS    = dexp_pkg::SAMPLE_BITS_DEF,
	parameter int LOG_TABLE_BITS = dexp_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dexp_pkg::dp_cmd_t                     cmd,
	input  logic                                  cfg_we,
	input  logic [dexp_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [dexp_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]         left_sample,
	input  logic signed [SAMPLE_BITS-1:0]         right_sample,
	input  logic                                  block_last,
	output logic signed [SAMPLE_BITS-1:0]         left_out,
	output logic signed [SAMPLE_BITS-1:0]         right_out,
	output logic signed [15:0]                    gain_reduction,
	output logic signed [15:0]                    block_max_reduction,
	output logic                                  block_done
);

	localparam int S   = SAMPLE_BITS;
	localparam int L   = LOG_TABLE_BITS;
	localparam int EW  = $clog2(S);
	localparam int L2W = EW + 17;
	localparam logic signed [15:0] FLOOR_Q8     = -16'sd25600;
	localparam logic signed [23:0] FLOOR_ENV    = -24'sd6553600;
	localparam logic signed [19:0] DB_PER_LOG2  = 20'sd394566;
	localparam logic signed [14:0] LOG2_PER_DB  = 15'sd10885;
	localparam logic signed [S+2:0] SAT_HI = (S+3)'((64'd1 << (S-1)) - 64'd1);
	localparam logic signed [S+2:0] SAT_LO = -SAT_HI - (S+3)'(1);

	// configuration registers
	logic signed [14:0] thr_q;
	logic [15:0]        slope_q;
	logic [23:0]        attack_q;
	logic [23:0]        release_q;
	logic [1:0]         chan_q;

	// state
	logic signed [23:0] env_q;
	logic signed [23:0] bmin_q;

	// working registers
	logic signed [S-1:0] l_q, r_q;
	logic                last_q, stereo_q;
	logic [S-1:0]        peak_q;
	logic                zero_q;
	logic [31:0]         x_q;
	logic [15:0]         frac_q;
	logic signed [15:0]  level_q;
	logic signed [15:0]  target_q;
	logic signed [23:0]  t16_q;
	logic [23:0]         dabs_q;
	logic                dneg_q;
	logic [23:0]         alpha_q;
	logic                mute_q;
	logic [15:0]         f_q;
	logic [6:0]          sh_q;
	logic [30:0]         g_q;
	logic signed [S-1:0] lo_q, ro_q;

	function automatic logic [30:0] exp2_frac(input logic [3:0] k);
		case (k)
			4'd0:    exp2_frac = 31'd1518500250;
			4'd1:    exp2_frac = 31'd1276901417;
			4'd2:    exp2_frac = 31'd1170923762;
			4'd3:    exp2_frac = 31'd1121280436;
			4'd4:    exp2_frac = 31'd1097253708;
			4'd5:    exp2_frac = 31'd1085434106;
			4'd6:    exp2_frac = 31'd1079572136;
			4'd7:    exp2_frac = 31'd1076653033;
			4'd8:    exp2_frac = 31'd1075196444;
			4'd9:    exp2_frac = 31'd1074468888;
			4'd10:   exp2_frac = 31'd1074105294;
			4'd11:   exp2_frac = 31'd1073923544;
			4'd12:   exp2_frac = 31'd1073832680;
			4'd13:   exp2_frac = 31'd1073787251;
			4'd14:   exp2_frac = 31'd1073764537;
			default: exp2_frac = 31'd1073753181;
		endcase
	endfunction

	// Q16 envelope to Q8.8, rounding toward zero
	function automatic logic signed [15:0] to_q8(input logic signed [23:0] v);
		logic signed [23:0] t;
		t = v + (v[23] ? 24'sd255 : 24'sd0);
		to_q8 = 16'(t >>> 8);
	endfunction

	// input magnitudes and linked peak
	logic [S-1:0] mag_l, mag_r, peak_in;
	assign mag_l   = left_sample[S-1]  ? S'(-left_sample)  : S'(left_sample);
	assign mag_r   = right_sample[S-1] ? S'(-right_sample) : S'(right_sample);
	assign peak_in = (chan_q[1] && mag_r > mag_l) ? mag_r : mag_l;

	// leading one of the peak
	logic [EW-1:0] e_d;
	always_comb begin
		e_d = '0;
		for (int i = 0; i < S; i++)
			if (peak_q[i])
				e_d = EW'(i);
	end

	// log table index from the bits below the leading one
	logic [S+L-1:0] pw;
	logic [L-1:0]   idx;
	assign pw  = ({{L{1'b0}}, peak_q} << L) >> e_d;
	assign idx = pw[L-1:0];

	// squaring step of the log2 fraction
	logic [63:0] sq_p;
	logic [33:0] xs;
	assign sq_p = x_q * x_q;
	assign xs   = sq_p[63:30];

	// log2 to dB
	logic signed [L2W-1:0]   l2;
	logic signed [L2W+19:0]  dbp;
	logic signed [L2W-5:0]   dbv;
	assign l2  = {({1'b0, e_d} - (EW+1)'(S-1)), frac_q};
	assign dbp = l2 * DB_PER_LOG2;
	assign dbv = (L2W-4)'(dbp >>> 24);

	// target reduction below threshold
	logic signed [16:0] thr17, lvl17;
	logic [16:0]        below;
	logic [32:0]        red_p;
	logic [16:0]        red;
	assign thr17 = 17'(thr_q);
	assign lvl17 = 17'(level_q);
	assign below = 17'(thr17 - lvl17);
	assign red_p = below * slope_q;
	assign red   = red_p[32:16];

	// smoother difference and step
	logic signed [23:0] t16;
	logic signed [24:0] dd;
	logic [47:0]        sm_p;
	logic [23:0]        sm_m;
	assign t16  = 24'(target_q) <<< 8;
	assign dd   = 25'(env_q) - 25'(t16);
	assign sm_p = dabs_q * alpha_q;
	assign sm_m = sm_p[47:24];

	// log2 gain from the envelope
	logic signed [38:0] g2p;
	logic signed [22:0] g2;
	assign g2p = env_q * LOG2_PER_DB;
	assign g2  = 23'(g2p >>> 16);

	// exp2 fraction step: fraction bit 15-k selects 2^(2^-(k+1))
	logic [61:0] gs_p;
	assign gs_p = g_q * exp2_frac(cmd.step);

	// gain multiply, rounding and saturation (shared by both channels)
	logic signed [S-1:0]  ap_s;
	logic signed [S+32:0] ap_p;
	logic signed [S+2:0]  ap_r;
	logic signed [S-1:0]  ap_o;
	assign ap_s = cmd.apr ? r_q : l_q;
	assign ap_p = ap_s * $signed({1'b0, g_q}) + $signed((S+33)'(64'd1 << 29));
	assign ap_r = (S+3)'(ap_p >>> 30);
	always_comb begin
		if (ap_r > SAT_HI)
			ap_o = SAT_HI[S-1:0];
		else if (ap_r < SAT_LO)
			ap_o = SAT_LO[S-1:0];
		else
			ap_o = ap_r[S-1:0];
	end

	logic signed [23:0] mn;
	assign mn = (env_q < bmin_q) ? env_q : bmin_q;

	// configuration, envelope and block minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= -15'sd15360;
			slope_q   <= '0;
			attack_q  <= 24'd16441672;
			release_q <= 24'd16774720;
			chan_q    <= 2'd2;
			env_q     <= '0;
			bmin_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					dexp_pkg::REG_THRESHOLD: thr_q     <= cfg_data[14:0];
					dexp_pkg::REG_SLOPE:     slope_q   <= cfg_data[15:0];
					dexp_pkg::REG_ATTACK:    attack_q  <= cfg_data;
					dexp_pkg::REG_RELEASE:   release_q <= cfg_data;
					dexp_pkg::REG_CHANNELS:  chan_q    <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (cmd.sm2)
				env_q <= dneg_q ? t16_q - sm_m : t16_q + sm_m;
			if (cmd.out_load)
				bmin_q <= last_q ? 24'sd0 : mn;
		end
	end

	// frame working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			l_q      <= left_sample;
			r_q      <= right_sample;
			last_q   <= block_last;
			stereo_q <= chan_q[1];
			peak_q   <= peak_in;
		end
		if (cmd.norm) begin
			zero_q <= (peak_q == '0);
			x_q    <= 32'({1'b1, idx}) << (30 - L);
			frac_q <= '0;
		end
		if (cmd.sq) begin
			x_q    <= xs[31] ? xs[32:1] : xs[31:0];
			frac_q <= {frac_q[14:0], xs[31]};
		end
		if (cmd.db) begin
			if (zero_q || dbv < (L2W-4)'(FLOOR_Q8))
				level_q <= FLOOR_Q8;
			else
				level_q <= dbv[15:0];
		end
		if (cmd.tgt) begin
			if (lvl17 < thr17)
				target_q <= (red > 17'd25600) ? FLOOR_Q8 : 16'(-$signed(red));
			else
				target_q <= '0;
		end
		if (cmd.sm1) begin
			t16_q   <= t16;
			dneg_q  <= dd[24];
			dabs_q  <= dd[24] ? 24'(-dd) : dd[23:0];
			alpha_q <= (t16 < env_q) ? attack_q : release_q;
		end
		if (cmd.ginit) begin
			mute_q <= (env_q <= FLOOR_ENV);
			f_q    <= g2[15:0];
			sh_q   <= 7'(-g2[22:16]);
			g_q    <= 31'd1 << 30;
		end
		if (cmd.gstep && f_q[4'd15 - cmd.step])
			g_q <= gs_p[60:30];
		if (cmd.gfin) begin
			if (mute_q || sh_q >= 7'd31)
				g_q <= '0;
			else
				g_q <= g_q >> sh_q[4:0];
		end
		if (cmd.apl)
			lo_q <= ap_o;
		if (cmd.apr)
			ro_q <= stereo_q ? ap_o : '0;
		if (cmd.out_load) begin
			left_out            <= lo_q;
			right_out           <= ro_q;
			gain_reduction      <= to_q8(env_q);
			block_max_reduction <= last_q ? to_q8(mn) : 16'sd0;
			block_done          <= last_q;
		end
	end

endmodule

/* design/downward_expander_gate.sv */
// One frame at a time: a new word is accepted only after the last result is loaded.
// The two 16-step loops (log2 squaring and exp2 gain product), one step per cycle
// in the datapath, take up most of each frame.
// A finished result waits in the output register; the next word enters meanwhile.
// Reset (arst_n low, asynchronous): configuration registers to defaults,
// envelope and block minimum to 0 dB, controller idle, no result pending.
// ----------------------------------------------------------------------------
// Downward expander gate top level
// Stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
`include "downward_expander_gate_assert.svh"

module downward_expander_gate #(
	parameter int SAMPLE_BITS    = dexp_pkg::SAMPLE_BITS_DEF,
	parameter int LOG_TABLE_BITS = dexp_pkg::LOG_TABLE_BITS_DEF,
	localparam int IN_W  = ((2*SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2*SAMPLE_BITS + 32 + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// left_sample, right_sample
	input  logic [IN_W-1:0]                   s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// left_out, right_out, gain_reduction, block_max_reduction
	output logic [OUT_W-1:0]                  m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [dexp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [dexp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int S = SAMPLE_BITS;

	dexp_pkg::dp_cmd_t   cmd;
	logic signed [S-1:0] left_out, right_out;
	logic signed [15:0]  gain_reduction, block_max_reduction;
	logic [IN_W-1:0]     in_pad;

	assign in_pad = s_tdata;

	dexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd)
	);

	dexp_datapath #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.LOG_TABLE_BITS (LOG_TABLE_BITS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.cfg_we              (cfg_we),
		.cfg_addr            (cfg_addr),
		.cfg_data            (cfg_data),
		.left_sample         (in_pad[S-1:0]),
		.right_sample        (in_pad[2*S-1:S]),
		.block_last          (s_tlast),
		.left_out            (left_out),
		.right_out           (right_out),
		.gain_reduction      (gain_reduction),
		.block_max_reduction (block_max_reduction),
		.block_done          (m_tlast)
	);

	// pack the result word, lowest field first
	assign m_tdata = OUT_W'({block_max_reduction, gain_reduction, right_out, left_out});

	// checks
	`DEG_ASSERT_NEXT(a_one_frame, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`DEG_ASSERT_IMP(a_load_free, clk, arst_n, cmd.out_load, !m_tvalid || m_tready)
	`DEG_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.out_load, m_tvalid)
	`DEG_ASSERT(a_meter_quiet, clk, arst_n, !m_tvalid || m_tlast || block_max_reduction == 16'sd0)

endmodule
